### hdl/bta_pkg.sv
// Shared types and constants for the boundary-tag first-fit allocator.
`timescale 1ns / 1ps
`default_nettype none
package bta_pkg;

  localparam int unsigned WORD_BYTES   = 8;
  localparam int unsigned TAG_OVERHEAD = 16;
  localparam logic [15:0] LIMIT_RESET  = 16'd32768;

  localparam logic [0:0] FUNC_ALLOC = 1'b0;
  localparam logic [0:0] FUNC_FREE  = 1'b1;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_RD_POS,
    OP_RD_NEXT,
    OP_STEP,
    OP_LATCH_BLK,
    OP_LATCH_FREE,
    OP_ADD_NEXT,
    OP_WR_SPLIT_HDR,
    OP_WR_SPLIT_FTR,
    OP_WR_REST_HDR,
    OP_WR_REST_FTR,
    OP_WR_WHOLE_HDR,
    OP_WR_WHOLE_FTR,
    OP_WR_GROW_HDR,
    OP_WR_GROW_FTR,
    OP_WR_FREE_HDR,
    OP_WR_FREE_FTR
  } cmd_op_t;

  typedef enum logic [2:0] {
    RES_KEEP,
    RES_FAIL,
    RES_POS,
    RES_TOP,
    RES_REL
  } res_src_t;

  typedef struct packed {
    cmd_op_t  op;
    res_src_t res;
    logic     publish;
  } dp_cmd_t;

  typedef struct packed {
    logic func_free;
    logic req_zero;
    logic addr_bad;
    logic top_zero;
    logic blk_bad;
    logic blk_free;
    logic fits;
    logic split;
    logic at_target;
    logic past_target;
    logic step_end;
    logic next_free_ok;
    logic grow_ok;
  } dp_status_t;

endpackage
`default_nettype wire

### hdl/bta_dp.sv
// Allocator datapath: tag memory, walk position, heap top and result registers.
`timescale 1ns / 1ps
`default_nettype none
module bta_dp #(
  parameter int HEAP_WORDS = 4096
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire bta_pkg::dp_cmd_t cmd,
  output bta_pkg::dp_status_t   status,
  input  wire logic [15:0]      heap_limit,
  input  wire logic             in_func,
  input  wire logic [15:0]      in_req,
  input  wire logic [14:0]      in_rel,
  output logic [14:0]           out_addr,
  output logic                  out_granted
);
  import bta_pkg::*;

  localparam int AW = (HEAP_WORDS > 1) ? $clog2(HEAP_WORDS) : 1;
  localparam logic [19:0] CAP_BYTES = 20'(HEAP_WORDS * WORD_BYTES);

  logic [15:0] mem [HEAP_WORDS];
  logic [15:0] rd_data_r;

  logic        func_r;
  logic [15:0] req_r;
  logic [14:0] rel_r;
  logic [16:0] need_r;
  logic [15:0] pos_r, prev_r, sz_r, start_r, total_r, top_r;
  logic        have_prev_r, prev_free_r;
  logic [15:0] res_addr_r;
  logic        res_ok_r;
  logic [14:0] out_addr_r;
  logic        out_granted_r;

  logic [15:0] sz_rd, nsz_rd, next_pos, target, cap_eff, need16;
  logic [16:0] step_sum;
  logic        rd_en, wr_en;
  logic [15:0] rd_off, wr_off, wr_data;

  function automatic logic [AW-1:0] widx(input logic [15:0] off);
    return AW'(off >> 3);
  endfunction

  function automatic logic [15:0] mk_tag(input logic [15:0] size, input logic alloc);
    return {size[15:3], 2'b00, alloc};
  endfunction

  assign sz_rd    = {rd_data_r[15:3], 3'b000};
  assign nsz_rd   = sz_rd;
  assign next_pos = pos_r + sz_r;
  assign target   = {1'b0, rel_r} - 16'(WORD_BYTES);
  assign step_sum = {1'b0, pos_r} + {1'b0, sz_rd};
  assign need16   = need_r[15:0];
  assign cap_eff  = ({4'b0000, heap_limit} < CAP_BYTES) ? heap_limit : CAP_BYTES[15:0];

  always_comb begin
    status.func_free    = func_r;
    status.req_zero     = (req_r == 16'd0);
    status.addr_bad     = (rel_r[14:3] == 12'd0) || (rel_r[2:0] != 3'd0);
    status.top_zero     = (top_r == 16'd0);
    status.blk_bad      = (sz_rd == 16'd0) || (sz_rd > (top_r - pos_r));
    status.blk_free     = ~rd_data_r[0];
    status.fits         = ~rd_data_r[0] && ({1'b0, sz_rd} >= need_r);
    status.split        = {2'b00, sz_rd} > ({1'b0, need_r} + 18'(TAG_OVERHEAD));
    status.at_target    = (pos_r == target);
    status.past_target  = (pos_r > target);
    status.step_end     = step_sum >= {1'b0, top_r};
    status.next_free_ok = (nsz_rd != 16'd0) && (nsz_rd <= (top_r - next_pos)) &&
                          ~rd_data_r[0];
    status.grow_ok      = (top_r <= cap_eff) &&
                          (need_r <= ({1'b0, cap_eff} - {1'b0, top_r}));
  end

  always_comb begin
    rd_en   = 1'b0;
    rd_off  = pos_r;
    wr_en   = 1'b0;
    wr_off  = pos_r;
    wr_data = mk_tag(need16, 1'b1);
    case (cmd.op)
      OP_RD_POS:  rd_en = 1'b1;
      OP_RD_NEXT: begin
        rd_en  = 1'b1;
        rd_off = next_pos;
      end
      OP_WR_SPLIT_HDR: wr_en = 1'b1;
      OP_WR_SPLIT_FTR: begin
        wr_en  = 1'b1;
        wr_off = pos_r + need16 - 16'(WORD_BYTES);
      end
      OP_WR_REST_HDR: begin
        wr_en   = 1'b1;
        wr_off  = pos_r + need16;
        wr_data = mk_tag(sz_r - need16, 1'b0);
      end
      OP_WR_REST_FTR: begin
        wr_en   = 1'b1;
        wr_off  = pos_r + sz_r - 16'(WORD_BYTES);
        wr_data = mk_tag(sz_r - need16, 1'b0);
      end
      OP_WR_WHOLE_HDR: begin
        wr_en   = 1'b1;
        wr_data = mk_tag(sz_r, 1'b1);
      end
      OP_WR_WHOLE_FTR: begin
        wr_en   = 1'b1;
        wr_off  = pos_r + sz_r - 16'(WORD_BYTES);
        wr_data = mk_tag(sz_r, 1'b1);
      end
      OP_WR_GROW_HDR: begin
        wr_en  = 1'b1;
        wr_off = top_r;
      end
      OP_WR_GROW_FTR: begin
        wr_en  = 1'b1;
        wr_off = top_r + need16 - 16'(WORD_BYTES);
      end
      OP_WR_FREE_HDR: begin
        wr_en   = 1'b1;
        wr_off  = start_r;
        wr_data = mk_tag(total_r, 1'b0);
      end
      OP_WR_FREE_FTR: begin
        wr_en   = 1'b1;
        wr_off  = start_r + total_r - 16'(WORD_BYTES);
        wr_data = mk_tag(total_r, 1'b0);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[widx(wr_off)] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[widx(rd_off)];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_r       <= 16'd0;
      have_prev_r <= 1'b0;
    end else begin
      case (cmd.op)
        OP_LOAD: begin
          func_r      <= in_func;
          req_r       <= in_req;
          rel_r       <= in_rel;
          need_r      <= ({1'b0, in_req} + 17'(TAG_OVERHEAD + WORD_BYTES - 1)) &
                         ~17'(WORD_BYTES - 1);
          pos_r       <= 16'd0;
          have_prev_r <= 1'b0;
        end
        OP_STEP: begin
          prev_r      <= pos_r;
          prev_free_r <= ~rd_data_r[0];
          have_prev_r <= 1'b1;
          pos_r       <= step_sum[15:0];
        end
        OP_LATCH_BLK: sz_r <= sz_rd;
        OP_LATCH_FREE: begin
          sz_r <= sz_rd;
          if (have_prev_r && prev_free_r) begin
            start_r <= prev_r;
            total_r <= sz_rd + (pos_r - prev_r);
          end else begin
            start_r <= pos_r;
            total_r <= sz_rd;
          end
        end
        OP_ADD_NEXT:    total_r <= total_r + nsz_rd;
        OP_WR_GROW_FTR: top_r   <= top_r + need16;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.res)
      RES_FAIL: begin
        res_addr_r <= 16'd0;
        res_ok_r   <= 1'b0;
      end
      RES_POS: begin
        res_addr_r <= pos_r + 16'(WORD_BYTES);
        res_ok_r   <= 1'b1;
      end
      RES_TOP: begin
        res_addr_r <= top_r + 16'(WORD_BYTES);
        res_ok_r   <= 1'b1;
      end
      RES_REL: begin
        res_addr_r <= {1'b0, rel_r};
        res_ok_r   <= 1'b1;
      end
      default: ;
    endcase
    if (cmd.publish) begin
      out_addr_r    <= res_addr_r[14:0];
      out_granted_r <= res_ok_r;
    end
  end

  assign out_addr    = out_addr_r;
  assign out_granted = out_granted_r;

endmodule
`default_nettype wire

### hdl/bta_ctrl.sv
// Allocator sequencer: walks blocks, issues tag reads and writes, hands off results.
`timescale 1ns / 1ps
`default_nettype none
module bta_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  output logic                    out_valid,
  input  wire logic               out_ready,
  input  wire bta_pkg::dp_status_t status,
  output bta_pkg::dp_cmd_t        cmd
);
  import bta_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE,
    S_START,
    S_READ,
    S_WAIT,
    S_FREAD,
    S_FWAIT,
    S_FHDR,
    S_FFTR,
    S_SPLIT_HDR,
    S_SPLIT_FTR,
    S_REST_HDR,
    S_REST_FTR,
    S_WHOLE_HDR,
    S_WHOLE_FTR,
    S_GROW,
    S_GROW_FTR,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd.op        = OP_NONE;
    cmd.res       = RES_KEEP;
    cmd.publish   = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = OP_LOAD;
          state_nxt = S_START;
        end
      end
      S_START: begin
        if (status.func_free) begin
          if (status.addr_bad || status.top_zero) begin
            cmd.res   = RES_FAIL;
            state_nxt = S_DONE;
          end else begin
            cmd.op    = OP_RD_POS;
            state_nxt = S_WAIT;
          end
        end else if (status.req_zero) begin
          cmd.res   = RES_FAIL;
          state_nxt = S_DONE;
        end else if (status.top_zero) begin
          state_nxt = S_GROW;
        end else begin
          cmd.op    = OP_RD_POS;
          state_nxt = S_WAIT;
        end
      end
      S_READ: begin
        cmd.op    = OP_RD_POS;
        state_nxt = S_WAIT;
      end
      S_WAIT: begin
        if (!status.func_free) begin
          if (status.blk_bad) begin
            state_nxt = S_GROW;
          end else if (status.fits) begin
            cmd.op    = OP_LATCH_BLK;
            state_nxt = status.split ? S_SPLIT_HDR : S_WHOLE_HDR;
          end else begin
            cmd.op    = OP_STEP;
            state_nxt = status.step_end ? S_GROW : S_READ;
          end
        end else if (status.blk_bad) begin
          cmd.res   = RES_FAIL;
          state_nxt = S_DONE;
        end else if (status.at_target) begin
          if (status.blk_free) begin
            cmd.res   = RES_FAIL;
            state_nxt = S_DONE;
          end else begin
            cmd.op    = OP_LATCH_FREE;
            state_nxt = status.step_end ? S_FHDR : S_FREAD;
          end
        end else if (status.past_target) begin
          cmd.res   = RES_FAIL;
          state_nxt = S_DONE;
        end else begin
          cmd.op = OP_STEP;
          if (status.step_end) begin
            cmd.res   = RES_FAIL;
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_READ;
          end
        end
      end
      S_FREAD: begin
        cmd.op    = OP_RD_NEXT;
        state_nxt = S_FWAIT;
      end
      S_FWAIT: begin
        if (status.next_free_ok) begin
          cmd.op = OP_ADD_NEXT;
        end
        state_nxt = S_FHDR;
      end
      S_FHDR: begin
        cmd.op    = OP_WR_FREE_HDR;
        state_nxt = S_FFTR;
      end
      S_FFTR: begin
        cmd.op    = OP_WR_FREE_FTR;
        cmd.res   = RES_REL;
        state_nxt = S_DONE;
      end
      S_SPLIT_HDR: begin
        cmd.op    = OP_WR_SPLIT_HDR;
        state_nxt = S_SPLIT_FTR;
      end
      S_SPLIT_FTR: begin
        cmd.op    = OP_WR_SPLIT_FTR;
        state_nxt = S_REST_HDR;
      end
      S_REST_HDR: begin
        cmd.op    = OP_WR_REST_HDR;
        state_nxt = S_REST_FTR;
      end
      S_REST_FTR: begin
        cmd.op    = OP_WR_REST_FTR;
        cmd.res   = RES_POS;
        state_nxt = S_DONE;
      end
      S_WHOLE_HDR: begin
        cmd.op    = OP_WR_WHOLE_HDR;
        state_nxt = S_WHOLE_FTR;
      end
      S_WHOLE_FTR: begin
        cmd.op    = OP_WR_WHOLE_FTR;
        cmd.res   = RES_POS;
        state_nxt = S_DONE;
      end
      S_GROW: begin
        if (status.grow_ok) begin
          cmd.op    = OP_WR_GROW_HDR;
          cmd.res   = RES_TOP;
          state_nxt = S_GROW_FTR;
        end else begin
          cmd.res   = RES_FAIL;
          state_nxt = S_DONE;
        end
      end
      S_GROW_FTR: begin
        cmd.op    = OP_WR_GROW_FTR;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.publish   = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

### hdl/boundary_tag_first_fit_allocator.sv
// Top level of the boundary-tag first-fit heap allocator.
//
// Input stream: one word per request. in_tuser is the function (0 allocate,
// 1 free); in_tdata carries the request size and the release address.
// Output stream: one word per request, the payload address and a grant flag.
// Configuration: APB register 0 at byte address 0 holds the heap limit.
//
// A request walks the implicit block list from offset 0, with one tag memory
// read and one decision per block visited. A request rejected before the
// walk answers without reading any tag. The single-port tag read paces the
// walk; one request is in flight at a time and the next word is taken once
// the result is handed off. The result sits in an output register, so a new
// word is accepted while a stalled result waits; a finished request holds
// until that slot frees. Reset empties the heap (top at zero) and sets the
// limit to 32768; the tag memory is not cleared since the walk only reads
// tags already written.
`timescale 1ns / 1ps
`default_nettype none
module boundary_tag_first_fit_allocator #(
  parameter int HEAP_WORDS = 4096
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // [15:0] request_bytes, [30:16] release_address, [31] zero
  input  wire logic [31:0] in_tdata,
  // [0] func
  input  wire logic        in_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // [14:0] payload_address, [15] zero
  output logic [15:0]      out_tdata,
  // [0] granted
  output logic             out_tuser,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);
  import bta_pkg::*;

  localparam logic CFG_IDX_LIMIT = 1'b0;

  logic [15:0] heap_limit_r;
  dp_cmd_t     cmd;
  dp_status_t  status;
  logic [14:0] res_addr;

  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      heap_limit_r <= LIMIT_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 (cfg_paddr[2] == CFG_IDX_LIMIT)) begin
      heap_limit_r <= cfg_pwdata[15:0];
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == CFG_IDX_LIMIT) ? {16'd0, heap_limit_r} : 32'd0;

  bta_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .status    (status),
    .cmd       (cmd)
  );

  bta_dp #(
    .HEAP_WORDS (HEAP_WORDS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .status      (status),
    .heap_limit  (heap_limit_r),
    .in_func     (in_tuser),
    .in_req      (in_tdata[15:0]),
    .in_rel      (in_tdata[30:16]),
    .out_addr    (res_addr),
    .out_granted (out_tuser)
  );

  assign out_tdata = {1'b0, res_addr};

endmodule
`default_nettype wire

### bench/tb_boundary_tag_first_fit_allocator.sv
// Self-checking bench for the boundary-tag first-fit allocator: predictor, stimulus, scoreboard.
`timescale 1ns / 1ps
module tb_boundary_tag_first_fit_allocator;
  import bta_pkg::*;

  localparam int unsigned HEAP_WORDS     = 4096;
  localparam int unsigned ALIGN_MASK     = 7;
  localparam logic [2:0]  REG_HEAP_LIMIT = 3'd0;

  typedef struct packed {
    logic [14:0] addr;
    logic        granted;
  } grant_t;

  typedef struct {
    logic [0:0]  func;
    logic [15:0] req;
    logic [14:0] rel;
    bit          typed;
    grant_t      want;
  } row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic        out_tuser;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  always #5 clk = ~clk;

  boundary_tag_first_fit_allocator #(.HEAP_WORDS(HEAP_WORDS)) DUT (
    .clk, .rst_n,
    .in_tvalid, .in_tready,
    .in_tdata,                // [15:0] request_bytes, [30:16] release_address, [31] zero
    .in_tuser,                // [0] func
    .out_tvalid, .out_tready,
    .out_tdata,               // [14:0] payload_address, [15] zero
    .out_tuser,               // [0] granted
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata, .cfg_prdata, .cfg_pready
  );

  // heap predictor state
  logic [15:0] heap_tags [HEAP_WORDS];
  int unsigned model_top;
  int unsigned model_limit;

  grant_t      grant_q [$];
  grant_t      typed_exp [int unsigned];
  int unsigned live_q [$];
  int unsigned words_issued = 0;
  int unsigned words_accepted = 0;
  int unsigned results_seen = 0;
  int unsigned errors = 0;
  int unsigned stall_pct = 32;

  function automatic int unsigned tag_rd(int unsigned off);
    int unsigned w;
    w = off / WORD_BYTES;
    if (w >= HEAP_WORDS) return 0;
    return 32'(heap_tags[w]);
  endfunction

  function automatic void tag_wr(int unsigned off, int unsigned tag);
    int unsigned w;
    w = off / WORD_BYTES;
    if (w < HEAP_WORDS) heap_tags[w] = 16'(tag);
  endfunction

  function automatic void put_block(int unsigned start, int unsigned size, int unsigned alloc);
    int unsigned tag;
    tag = (size & ~ALIGN_MASK) | (alloc & 1);
    tag_wr(start, tag);
    tag_wr(start + size - WORD_BYTES, tag);
  endfunction

  function automatic int unsigned block_len(int unsigned pos);
    int unsigned sz;
    sz = tag_rd(pos) & ~ALIGN_MASK;
    if (sz == 0 || sz > model_top - pos) return 0;
    return sz;
  endfunction

  function automatic grant_t grant_for_alloc(int unsigned req);
    int unsigned need, pos, cap, sz, rest;
    grant_t g;
    g = '0;
    if (req == 0) return g;
    need = (req + TAG_OVERHEAD + ALIGN_MASK) & ~ALIGN_MASK;
    pos = 0;
    while (pos < model_top) begin
      sz = block_len(pos);
      if (sz == 0) break;
      if ((tag_rd(pos) & 1) == 0 && sz >= need) begin
        rest = sz - need;
        if (rest > TAG_OVERHEAD) begin
          put_block(pos, need, 1);
          put_block(pos + need, rest, 0);
        end else begin
          put_block(pos, sz, 1);
        end
        g.addr = 15'(pos + WORD_BYTES);
        g.granted = 1'b1;
        return g;
      end
      pos += sz;
    end
    cap = HEAP_WORDS * WORD_BYTES;
    if (model_limit < cap) cap = model_limit;
    if (model_top > cap || need > cap - model_top) return g;
    put_block(model_top, need, 1);
    g.addr = 15'(model_top + WORD_BYTES);
    g.granted = 1'b1;
    model_top += need;
    return g;
  endfunction

  function automatic grant_t grant_for_release(int unsigned addr);
    int unsigned target, pos, prv, sz, start, total, nxt, nsz;
    bit prev_free, have_prev;
    grant_t g;
    g = '0;
    prv = 0;
    prev_free = 1'b0;
    have_prev = 1'b0;
    if (addr < WORD_BYTES || (addr & ALIGN_MASK) != 0) return g;
    target = addr - WORD_BYTES;
    pos = 0;
    while (pos < model_top) begin
      sz = block_len(pos);
      if (sz == 0) return g;
      if (pos == target) begin
        if ((tag_rd(pos) & 1) == 0) return g;
        start = pos;
        total = sz;
        nxt = pos + sz;
        if (have_prev && prev_free) begin
          start = prv;
          total += pos - prv;
        end
        if (nxt < model_top) begin
          nsz = block_len(nxt);
          if (nsz != 0 && (tag_rd(nxt) & 1) == 0) total += nsz;
        end
        put_block(start, total, 0);
        g.addr = 15'(addr);
        g.granted = 1'b1;
        return g;
      end
      if (pos > target) return g;
      prv = pos;
      prev_free = ((tag_rd(pos) & 1) == 0);
      have_prev = 1'b1;
      pos += sz;
    end
    return g;
  endfunction

  // scoreboard: results first, then newly accepted words
  always @(posedge clk) begin : scoreboard
    grant_t got, want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        results_seen++;
        got = '{out_tdata[14:0], out_tuser};
        if (grant_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected word addr=%0d granted=%0b", $time, got.addr, got.granted);
        end else begin
          want = grant_q.pop_front();
          if (got.addr !== want.addr) begin
            errors++;
            $display("%0t: payload_address expected %0d got %0d", $time, want.addr, got.addr);
          end
          if (got.granted !== want.granted) begin
            errors++;
            $display("%0t: granted expected %0b got %0b", $time, want.granted, got.granted);
          end
        end
      end
      if (in_tvalid && in_tready) begin
        if (in_tuser == FUNC_FREE) begin
          want = grant_for_release(32'(in_tdata[30:16]));
          if (want.granted) begin
            foreach (live_q[i]) begin
              if (live_q[i] == 32'(want.addr)) begin
                live_q.delete(i);
                break;
              end
            end
          end
        end else begin
          want = grant_for_alloc(32'(in_tdata[15:0]));
          if (want.granted) live_q.push_back(32'(want.addr));
        end
        if (typed_exp.exists(words_accepted)) want = typed_exp[words_accepted];
        grant_q.push_back(want);
        words_accepted++;
      end
    end
  end

  always @(posedge clk) out_tready <= ($urandom_range(0, 99) >= stall_pct);

  task automatic send_word(logic [0:0] f, logic [15:0] req, logic [14:0] rel);
    if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= f;
    in_tdata  <= {1'b0, rel, req};
    do @(posedge clk); while (!in_tready);
    words_issued++;
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (results_seen != words_issued) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic apb_access(logic wr, logic [2:0] addr, logic [31:0] wdata,
                            output logic [31:0] rdata);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= addr;
    cfg_pwdata  <= wdata;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    rdata = cfg_prdata;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  task automatic check_limit();
    logic [31:0] rd;
    @(posedge clk);
    apb_access(1'b0, REG_HEAP_LIMIT, '0, rd);
    if (rd[15:0] !== 16'(model_limit)) begin
      errors++;
      $display("%0t: heap limit readback expected %0d got %0d", $time, model_limit, rd[15:0]);
    end
  endtask

  task automatic set_limit(int unsigned value);
    logic [31:0] rd;
    wait_idle();
    apb_access(1'b1, REG_HEAP_LIMIT, value, rd);
    model_limit = value;
    check_limit();
  endtask

  task automatic pick_word(output logic [0:0] f, output logic [15:0] req,
                           output logic [14:0] rel);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    f    = FUNC_ALLOC;
    req  = 16'($urandom_range(0, 32768));
    rel  = 15'($urandom);
    if (roll < 70) begin
      if (live_q.size() == 0 || (live_q.size() < 24 && $urandom_range(0, 99) < 55)) begin
        f = FUNC_ALLOC;
        req = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(257, 2048))
                                          : 16'($urandom_range(1, 256));
      end else begin
        f = FUNC_FREE;
        rel = 15'(live_q[$urandom_range(0, live_q.size() - 1)]);
      end
    end else begin
      case (roll % 5)
        0: req = '0;
        1: req = 16'($urandom_range(0, 32768));
        2: f = FUNC_FREE;
        3: begin
          f = FUNC_FREE;
          rel = 15'($urandom_range(0, model_top) & ~ALIGN_MASK);
        end
        default: begin
          f = FUNC_FREE;
          rel = '0;
        end
      endcase
    end
  endtask

  task automatic run_random(int unsigned n);
    logic [0:0]  f;
    logic [15:0] req;
    logic [14:0] rel;
    repeat (n) begin
      pick_word(f, req, rel);
      send_word(f, req, rel);
    end
  endtask

  row_t directed_rows [24] = '{
    '{FUNC_ALLOC, 16'd0,     15'd0,     1'b1, '{15'd0,  1'b0}},  // zero request
    '{FUNC_FREE,  16'd0,     15'd0,     1'b1, '{15'd0,  1'b0}},  // free of null
    '{FUNC_FREE,  16'd0,     15'd8,     1'b1, '{15'd0,  1'b0}},  // empty heap
    '{FUNC_ALLOC, 16'd1,     15'd0,     1'b1, '{15'd8,  1'b1}},
    '{FUNC_ALLOC, 16'd8,     15'd0,     1'b1, '{15'd32, 1'b1}},
    '{FUNC_ALLOC, 16'd32768, 15'd0,     1'b1, '{15'd0,  1'b0}},  // oversized
    '{FUNC_FREE,  16'd0,     15'd9,     1'b1, '{15'd0,  1'b0}},  // unaligned
    '{FUNC_FREE,  16'd0,     15'd32,    1'b1, '{15'd32, 1'b1}},
    '{FUNC_FREE,  16'd0,     15'd32,    1'b1, '{15'd0,  1'b0}},  // double free
    '{FUNC_ALLOC, 16'd8,     15'd0,     1'b0, '{15'd0,  1'b0}},  // exact fit
    '{FUNC_ALLOC, 16'd100,   15'd0,     1'b0, '{15'd0,  1'b0}},
    '{FUNC_FREE,  16'd0,     15'd56,    1'b0, '{15'd0,  1'b0}},
    '{FUNC_ALLOC, 16'd40,    15'd0,     1'b0, '{15'd0,  1'b0}},  // split
    '{FUNC_ALLOC, 16'd40,    15'd0,     1'b0, '{15'd0,  1'b0}},  // whole, small remainder
    '{FUNC_FREE,  16'd0,     15'd32,    1'b0, '{15'd0,  1'b0}},
    '{FUNC_FREE,  16'd0,     15'd8,     1'b0, '{15'd0,  1'b0}},  // merge next
    '{FUNC_FREE,  16'd0,     15'd56,    1'b0, '{15'd0,  1'b0}},  // merge prev
    '{FUNC_FREE,  16'd0,     15'd112,   1'b0, '{15'd0,  1'b0}},
    '{FUNC_FREE,  16'd0,     15'd16,    1'b0, '{15'd0,  1'b0}},  // inside a block
    '{FUNC_FREE,  16'd0,     15'd32767, 1'b1, '{15'd0,  1'b0}},
    '{FUNC_FREE,  16'd0,     15'd32760, 1'b0, '{15'd0,  1'b0}},  // past top
    '{FUNC_ALLOC, 16'd32767, 15'd0,     1'b1, '{15'd0,  1'b0}},
    '{FUNC_ALLOC, 16'd160,   15'd0,     1'b0, '{15'd0,  1'b0}},  // grow past free block
    '{FUNC_FREE,  16'd0,     15'd176,   1'b0, '{15'd0,  1'b0}}
  };

  initial begin
    foreach (heap_tags[i]) heap_tags[i] = '0;
    model_top = 0;
    model_limit = 32'(LIMIT_RESET);
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    check_limit();

    foreach (directed_rows[i]) begin
      if (directed_rows[i].typed) typed_exp[words_issued] = directed_rows[i].want;
      send_word(directed_rows[i].func, directed_rows[i].req, directed_rows[i].rel);
    end

    run_random(420);
    set_limit(16);          // no growth at all
    run_random(120);
    set_limit(32768);
    stall_pct = 0;          // back-to-back stretch
    run_random(400);
    stall_pct = 32;
    set_limit(2000);
    run_random(400);
    set_limit(600);
    run_random(310);

    wait_idle();
    repeat (40) @(posedge clk);
    if (grant_q.size() != 0) begin
      errors += grant_q.size();
      $display("%0t: %0d expected words never arrived", $time, grant_q.size());
    end
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

### files.f
hdl/bta_pkg.sv
hdl/bta_dp.sv
hdl/bta_ctrl.sv
hdl/boundary_tag_first_fit_allocator.sv
bench/tb_boundary_tag_first_fit_allocator.sv
